// ----- design/sds_pkg.sv -----
// Shared types, constants and helpers of the SCAN disk scheduler.
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;

	localparam int MAX_REQUESTS = 64;
	localparam int CYL_BITS     = 16;
	localparam int IDX_BITS     = $clog2(MAX_REQUESTS);
	localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
	localparam int DIST_BITS    = CYL_BITS + 1;
	localparam int TOTAL_BITS   = 24;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_BITS = 2;

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
	localparam logic [DIST_BITS-1:0]  CYL_FULL  = DIST_BITS'(1) << CYL_BITS;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_DISK_CYLINDERS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_HEAD     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SWEEP_UP       = 2'd2;

	typedef struct packed {
		logic [CYL_BITS-1:0] request_cylinder;
		logic                last_request;
	} request_t;

	typedef struct packed {
		logic [CYL_BITS-1:0]   served_cylinder;
		logic [DIST_BITS-1:0]  seek_distance;
		logic [TOTAL_BITS-1:0] total_seek;
		logic                  overflow;
		logic                  last_served;
	} result_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] disk_cylinders;
		logic [CYL_BITS-1:0]  start_head;
		logic                 sweep_up;
	} cfg_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic [CYL_BITS-1:0] cylinder;
		logic                last;
		logic                drop;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} qout_t;

	function automatic logic [CYL_BITS-1:0] abs_diff(input logic [CYL_BITS-1:0] a,
		input logic [CYL_BITS-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage
`default_nettype wire

// ----- design/sds_front.sv -----
// Front end: accepts requests, counts the batch and marks requests past capacity.
`timescale 1ns / 1ps
`default_nettype none
module sds_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sds_pkg::request_t request,
	input  wire logic              qfull,
	output logic                   busy,
	output logic                   push,
	output sds_pkg::qentry_t       entry
);

	logic [sds_pkg::CNT_BITS-1:0] fcount_q;
	logic                         full_batch;

	assign busy       = qfull;
	assign push       = start && !qfull;
	assign full_batch = (fcount_q == sds_pkg::CNT_BITS'(sds_pkg::MAX_REQUESTS));

	// Classify the incoming transaction
	always_comb begin
		entry.cylinder = request.request_cylinder;
		entry.last     = request.last_request;
		entry.drop     = full_batch;
	end

	// Track requests of the current batch; restart on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= '0;
		end else if (push) begin
			if (request.last_request) begin
				fcount_q <= '0;
			end else if (!full_batch) begin
				fcount_q <= fcount_q + sds_pkg::CNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/sds_queue.sv -----
// Short queue of classified requests between front and back.
`timescale 1ns / 1ps
`default_nettype none
module sds_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sds_pkg::qentry_t entry,
	input  wire logic             pop,
	output logic                  qfull,
	output sds_pkg::qout_t        qout
);

	sds_pkg::qentry_t              slot_q [sds_pkg::QUEUE_DEPTH];
	logic [sds_pkg::QPTR_BITS-1:0] wptr_q;
	logic [sds_pkg::QPTR_BITS-1:0] rptr_q;
	logic [sds_pkg::QCNT_BITS-1:0] cnt_q;
	logic                          do_pop;

	assign qfull      = (cnt_q == sds_pkg::QCNT_BITS'(sds_pkg::QUEUE_DEPTH));
	assign do_pop     = pop && (cnt_q != '0);
	assign qout.valid = (cnt_q != '0);
	assign qout.entry = slot_q[rptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= entry;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + sds_pkg::QPTR_BITS'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + sds_pkg::QPTR_BITS'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + sds_pkg::QCNT_BITS'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - sds_pkg::QCNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/sds_back.sv -----
// Back end: request store and the SCAN selection sequencer that emits results.
`timescale 1ns / 1ps
`default_nettype none
module sds_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sds_pkg::qout_t  qout,
	input  wire sds_pkg::cfg_t   cfg,
	output logic                 pop,
	output logic                 result_valid,
	output sds_pkg::result_t     result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_CALC = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]                     state_q;
	logic [sds_pkg::CYL_BITS-1:0]   mem [sds_pkg::MAX_REQUESTS];
	logic [sds_pkg::CNT_BITS-1:0]   count_q;
	logic [sds_pkg::CNT_BITS-1:0]   n_q;
	logic [sds_pkg::CNT_BITS-1:0]   k_q;
	logic [sds_pkg::CNT_BITS-1:0]   rd_idx_q;
	logic [sds_pkg::IDX_BITS-1:0]   rd_idx_s1;
	logic                           rd_valid_s1;
	logic [sds_pkg::CYL_BITS-1:0]   rdata_s1;
	logic [sds_pkg::MAX_REQUESTS-1:0] served_q;
	logic                           dflag_q;
	logic                           up_q;
	logic                           turned_q;
	logic [sds_pkg::CYL_BITS-1:0]   head_q;
	logic [sds_pkg::CYL_BITS-1:0]   edge_q;
	logic                           bfound_q;
	logic [sds_pkg::CYL_BITS-1:0]   bbest_val_q;
	logic [sds_pkg::IDX_BITS-1:0]   bbest_idx_q;
	logic                           ufound_q;
	logic [sds_pkg::CYL_BITS-1:0]   ubest_val_q;
	logic [sds_pkg::IDX_BITS-1:0]   ubest_idx_q;
	logic [sds_pkg::DIST_BITS-1:0]  dist_q;
	logic [sds_pkg::TOTAL_BITS-1:0] total_q;
	logic                           result_valid_q;
	sds_pkg::result_t               result_q;

	logic                           store_we;
	logic [sds_pkg::CNT_BITS-1:0]   n_next;
	logic [sds_pkg::DIST_BITS-1:0]  cyl_c;
	logic [sds_pkg::CYL_BITS-1:0]   edge_c;
	logic                           issue;
	logic                           live;
	logic                           in_side;
	logic                           b_better;
	logic                           u_better;
	logic [sds_pkg::CNT_BITS-1:0]   n_m1;
	logic                           scan_done;
	logic                           use_b;
	logic [sds_pkg::CYL_BITS-1:0]   pick_val;
	logic [sds_pkg::IDX_BITS-1:0]   pick_idx;
	logic [sds_pkg::DIST_BITS-1:0]  dist_c;
	logic [sds_pkg::TOTAL_BITS:0]   sum_c;
	logic                           last_k;

	assign pop      = (state_q == S_IDLE) && qout.valid;
	assign store_we = pop && !qout.entry.drop;
	assign n_next   = count_q + sds_pkg::CNT_BITS'(store_we);

	// Clamp the cylinder count and derive the turn edge
	always_comb begin
		if (cfg.disk_cylinders == '0) begin
			cyl_c = sds_pkg::DIST_BITS'(1);
		end else if (cfg.disk_cylinders > sds_pkg::CYL_FULL) begin
			cyl_c = sds_pkg::CYL_FULL;
		end else begin
			cyl_c = cfg.disk_cylinders;
		end
		edge_c = cfg.sweep_up ? sds_pkg::CYL_BITS'(cyl_c - sds_pkg::DIST_BITS'(1)) : '0;
	end

	// Compare one stored request against both running bests
	assign issue     = (state_q == S_SCAN) && (rd_idx_q < n_q);
	assign live      = rd_valid_s1 && !served_q[rd_idx_s1];
	assign in_side   = up_q ? (rdata_s1 >= head_q) : (rdata_s1 <= head_q);
	assign b_better  = !bfound_q || (up_q ? (rdata_s1 < bbest_val_q) : (rdata_s1 > bbest_val_q));
	assign u_better  = !ufound_q || (up_q ? (rdata_s1 > ubest_val_q) : (rdata_s1 < ubest_val_q));
	assign n_m1      = n_q - sds_pkg::CNT_BITS'(1);
	assign scan_done = rd_valid_s1 && (rd_idx_s1 == n_m1[sds_pkg::IDX_BITS-1:0]);

	// Choose the next request and its seek distance
	always_comb begin
		use_b    = !turned_q && bfound_q;
		pick_val = use_b ? bbest_val_q : ubest_val_q;
		pick_idx = use_b ? bbest_idx_q : ubest_idx_q;
		if (!use_b && !turned_q) begin
			dist_c = {1'b0, sds_pkg::abs_diff(edge_q, head_q)}
				+ {1'b0, sds_pkg::abs_diff(pick_val, edge_q)};
		end else begin
			dist_c = {1'b0, sds_pkg::abs_diff(pick_val, head_q)};
		end
	end

	assign sum_c  = {1'b0, total_q} + (sds_pkg::TOTAL_BITS + 1)'(dist_q);
	assign last_k = ((k_q + sds_pkg::CNT_BITS'(1)) == n_q);

	// Request store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store_we) begin
			mem[count_q[sds_pkg::IDX_BITS-1:0]] <= qout.entry.cylinder;
		end
		rdata_s1 <= mem[rd_idx_q[sds_pkg::IDX_BITS-1:0]];
	end

	// Sequence loading, scanning and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			n_q            <= '0;
			k_q            <= '0;
			rd_idx_q       <= '0;
			rd_idx_s1      <= '0;
			rd_valid_s1    <= 1'b0;
			served_q       <= '0;
			dflag_q        <= 1'b0;
			up_q           <= 1'b1;
			turned_q       <= 1'b0;
			head_q         <= '0;
			edge_q         <= '0;
			bfound_q       <= 1'b0;
			bbest_val_q    <= '0;
			bbest_idx_q    <= '0;
			ufound_q       <= 1'b0;
			ubest_val_q    <= '0;
			ubest_idx_q    <= '0;
			dist_q         <= '0;
			total_q        <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= (state_q == S_OUT);
			rd_valid_s1    <= issue;
			rd_idx_s1      <= rd_idx_q[sds_pkg::IDX_BITS-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						count_q <= n_next;
						if (qout.entry.drop) begin
							dflag_q <= 1'b1;
						end
						if (qout.entry.last) begin
							n_q      <= n_next;
							k_q      <= '0;
							up_q     <= cfg.sweep_up;
							edge_q   <= edge_c;
							head_q   <= cfg.start_head;
							turned_q <= 1'b0;
							total_q  <= '0;
							rd_idx_q <= '0;
							bfound_q <= 1'b0;
							ufound_q <= 1'b0;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + sds_pkg::CNT_BITS'(1);
					end
					if (live && in_side && b_better) begin
						bfound_q    <= 1'b1;
						bbest_val_q <= rdata_s1;
						bbest_idx_q <= rd_idx_s1;
					end
					if (live && u_better) begin
						ufound_q    <= 1'b1;
						ubest_val_q <= rdata_s1;
						ubest_idx_q <= rd_idx_s1;
					end
					if (scan_done) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					served_q[pick_idx] <= 1'b1;
					dist_q             <= dist_c;
					head_q             <= pick_val;
					result_q.served_cylinder <= pick_val;
					if (!use_b) begin
						turned_q <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					total_q <= sum_c[sds_pkg::TOTAL_BITS] ? sds_pkg::TOTAL_MAX
						: sum_c[sds_pkg::TOTAL_BITS-1:0];
					result_q.seek_distance <= dist_q;
					result_q.total_seek    <= sum_c[sds_pkg::TOTAL_BITS] ? sds_pkg::TOTAL_MAX
						: sum_c[sds_pkg::TOTAL_BITS-1:0];
					result_q.overflow      <= dflag_q;
					result_q.last_served   <= last_k;
					k_q                    <= k_q + sds_pkg::CNT_BITS'(1);
					rd_idx_q               <= '0;
					bfound_q               <= 1'b0;
					ufound_q               <= 1'b0;
					if (last_k) begin
						served_q <= '0;
						count_q  <= '0;
						dflag_q  <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ----- design/scan_disk_scheduler.sv -----
// Top level of the SCAN disk scheduler: configuration registers, front, queue and back.
// Requests are taken one per cycle while the four-entry queue has room; busy rises when
// it fills during emission. Each result takes a scan of registered store reads over all
// n stored requests, then a selection state and an output state, and is registered.
// Results cannot be stalled.
// Reset clears all control state and returns the settings to their defaults; the request store is left as is.
`timescale 1ns / 1ps
`default_nettype none
module scan_disk_scheduler (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire sds_pkg::request_t                 request,
	output logic                                   result_valid,
	output sds_pkg::result_t                       result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sds_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [sds_pkg::DIST_BITS-1:0]     cfg_data
);

	sds_pkg::cfg_t    cfg_q;
	sds_pkg::qentry_t entry;
	sds_pkg::qout_t   qout;
	logic             push;
	logic             pop;
	logic             qfull;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disk_cylinders <= sds_pkg::CYL_FULL;
			cfg_q.start_head     <= '0;
			cfg_q.sweep_up       <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sds_pkg::CFG_DISK_CYLINDERS: cfg_q.disk_cylinders <= cfg_data;
				sds_pkg::CFG_START_HEAD: begin
					cfg_q.start_head <= cfg_data[sds_pkg::CYL_BITS-1:0];
				end
				sds_pkg::CFG_SWEEP_UP: cfg_q.sweep_up <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	sds_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.qfull   (qfull),
		.busy    (busy),
		.push    (push),
		.entry   (entry)
	);

	sds_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.pop    (pop),
		.qfull  (qfull),
		.qout   (qout)
	);

	sds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qout         (qout),
		.cfg          (cfg_q),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the SCAN disk scheduler against a service-order predictor.
`timescale 1ns / 1ps
module testbench;

	localparam int LIMIT_CYCLES = 600000;
	localparam int RANDOM_ITEMS = 220;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES = 100;
	localparam logic [sds_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

	// Predicts the elevator service order of each batch and checks results against it
	class scan_order_board;
		logic [sds_pkg::DIST_BITS-1:0] cyl_count = sds_pkg::DIST_BITS'(65536);
		logic [sds_pkg::CYL_BITS-1:0]  start_head = '0;
		bit                            sweep = 1'b1;
		int                            store [sds_pkg::MAX_REQUESTS];
		bit                            marks [sds_pkg::MAX_REQUESTS];
		int                            count = 0;
		bit                            dropped = 1'b0;
		sds_pkg::result_t              service_order [$];
		int                            errors = 0;

		function void write_reg(logic [sds_pkg::CFG_IDX_BITS-1:0] idx,
			logic [sds_pkg::DIST_BITS-1:0] data);
			case (idx)
				sds_pkg::CFG_DISK_CYLINDERS: cyl_count = data;
				sds_pkg::CFG_START_HEAD:     start_head = data[sds_pkg::CYL_BITS-1:0];
				sds_pkg::CFG_SWEEP_UP:       sweep = data[0];
				default: ;
			endcase
		endfunction

		// Find the next unserved request; bounded keeps it on the sweep side of the head
		function int pick(bit up, bit bounded, int head);
			int best;
			best = -1;
			for (int i = 0; i < count; i++) begin
				if (marks[i])
					continue;
				if (bounded && (up ? (store[i] < head) : (store[i] > head)))
					continue;
				if (best < 0 || (up ? (store[i] < store[best]) : (store[i] > store[best])))
					best = i;
			end
			return best;
		endfunction

		// Store one request; on the last one, lay out the whole service order
		function void take_request(sds_pkg::request_t r);
			int cyl, rim, head, pending, seek_len, total, idx, n;
			bit turned;
			sds_pkg::result_t res;
			if (count < sds_pkg::MAX_REQUESTS) begin
				store[count] = int'(r.request_cylinder);
				marks[count] = 1'b0;
				count++;
			end else begin
				dropped = 1'b1;
			end
			if (!r.last_request)
				return;
			cyl = int'(cyl_count);
			if (cyl == 0)
				cyl = 1;
			if (cyl > (1 << sds_pkg::CYL_BITS))
				cyl = 1 << sds_pkg::CYL_BITS;
			rim = sweep ? cyl - 1 : 0;
			head = int'(start_head);
			total = 0;
			pending = 0;
			turned = 1'b0;
			n = count;
			for (int k = 0; k < n; k++) begin
				idx = -1;
				if (!turned) begin
					idx = pick(sweep, 1'b1, head);
					// Nothing left this way: run to the edge and fold the trip into the next seek
					if (idx < 0) begin
						turned = 1'b1;
						pending = (rim > head) ? rim - head : head - rim;
						head = rim;
					end
				end
				if (idx < 0)
					idx = pick(!sweep, 1'b0, head);
				marks[idx] = 1'b1;
				seek_len = ((store[idx] > head) ? store[idx] - head : head - store[idx])
					+ pending;
				pending = 0;
				head = store[idx];
				total += seek_len;
				if (total > int'(sds_pkg::TOTAL_MAX))
					total = int'(sds_pkg::TOTAL_MAX);
				res.served_cylinder = sds_pkg::CYL_BITS'(store[idx]);
				res.seek_distance = sds_pkg::DIST_BITS'(seek_len);
				res.total_seek = sds_pkg::TOTAL_BITS'(total);
				res.overflow = dropped;
				res.last_served = (k == n - 1);
				service_order.push_back(res);
			end
			count = 0;
			dropped = 1'b0;
		endfunction

		function void check_served(sds_pkg::result_t got);
			sds_pkg::result_t want;
			if (service_order.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: cyl %0d dist %0d total %0d ovf %0b last %0b",
						got.served_cylinder, got.seek_distance, got.total_seek,
						got.overflow, got.last_served);
				return;
			end
			want = service_order.pop_front();
			if (got.served_cylinder !== want.served_cylinder
					|| got.seek_distance !== want.seek_distance
					|| got.total_seek !== want.total_seek
					|| got.overflow !== want.overflow
					|| got.last_served !== want.last_served) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch expected: cyl %0d dist %0d total %0d ovf %0b last %0b",
						want.served_cylinder, want.seek_distance, want.total_seek,
						want.overflow, want.last_served);
					$display("         actual:   cyl %0d dist %0d total %0d ovf %0b last %0b",
						got.served_cylinder, got.seek_distance, got.total_seek,
						got.overflow, got.last_served);
				end
			end
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic                               busy;
	sds_pkg::request_t                  request = '0;
	logic                               result_valid;
	sds_pkg::result_t                   result;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [sds_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
	logic [sds_pkg::DIST_BITS-1:0]      cfg_data = '0;

	scan_order_board board = new();
	int cycles = 0;
	int items = 0;
	int batch_no = 0;
	int last_cyl = 0;

	scan_disk_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Check every strobed result
	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_served(result);
	end

	// Mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Request cylinders: ties at the head, repeats, extremes, in-range and anywhere
	function automatic int pick_cylinder();
		int r, cyl;
		r = $urandom_range(0, 99);
		cyl = int'(board.cyl_count);
		if (cyl < 1)
			cyl = 1;
		if (cyl > 65536)
			cyl = 65536;
		if (r < 15)
			return int'(board.start_head);
		if (r < 28)
			return last_cyl;
		if (r < 43)
			return $urandom_range(0, 65535);
		if (r < 50)
			return 0;
		if (r < 55)
			return 65535;
		return $urandom_range(0, cyl - 1);
	endfunction

	function automatic logic [sds_pkg::DIST_BITS-1:0] pick_cyl_count();
		case ($urandom_range(0, 8))
			0: return sds_pkg::DIST_BITS'(0);
			1: return sds_pkg::DIST_BITS'(1);
			2: return sds_pkg::DIST_BITS'(2);
			3: return sds_pkg::DIST_BITS'(65535);
			4: return sds_pkg::DIST_BITS'(65536);
			5: return sds_pkg::DIST_BITS'(65537);
			6: return sds_pkg::DIST_BITS'(131071);
			7: return sds_pkg::DIST_BITS'($urandom_range(3, 300));
			default: return sds_pkg::DIST_BITS'($urandom_range(1, 131071));
		endcase
	endfunction

	// Send one request transaction after an optional gap; returns at a falling edge
	task automatic send_request(int cyl, bit last, int gap);
		sds_pkg::request_t r;
		if (gap > 0) begin
			r.request_cylinder = sds_pkg::CYL_BITS'($urandom);
			r.last_request = 1'($urandom);
			start <= 1'b0;
			request <= r;
			repeat (gap) @(negedge clk);
		end
		r.request_cylinder = sds_pkg::CYL_BITS'(cyl);
		r.last_request = last;
		start <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy);
		board.take_request(r);
		last_cyl = cyl;
		@(negedge clk);
	endtask

	// Hold off until every expected result has come and the block has settled
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (board.service_order.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [sds_pkg::CFG_IDX_BITS-1:0] idx,
		logic [sds_pkg::DIST_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Drain, then program all three registers; upper data bits get junk where unused
	task automatic set_config(logic [sds_pkg::DIST_BITS-1:0] cyl,
		logic [sds_pkg::CYL_BITS-1:0] head, bit up);
		wait_drained();
		write_reg(sds_pkg::CFG_DISK_CYLINDERS, cyl);
		write_reg(sds_pkg::CFG_START_HEAD, {1'($urandom), head});
		write_reg(sds_pkg::CFG_SWEEP_UP, {16'($urandom), up});
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED, sds_pkg::DIST_BITS'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int size, r;
		bit burst;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset settings, single request tied at the head
		send_request(0, 1'b1, 0);
		// Both extremes and equal cylinders
		send_request(65535, 1'b0, 0);
		send_request(0, 1'b0, 1);
		send_request(100, 1'b0, 0);
		send_request(100, 1'b1, 0);
		// Downward sweep with a tie at the head, a turn and a request beyond the disk
		set_config(sds_pkg::DIST_BITS'(2000), 16'd1000, 1'b0);
		send_request(1000, 1'b0, 0);
		send_request(500, 1'b0, 0);
		send_request(2000, 1'b0, 2);
		send_request(1500, 1'b0, 0);
		send_request(999, 1'b1, 0);
		// Zero cylinders taken as one: head and requests beyond the edge
		set_config(sds_pkg::DIST_BITS'(0), 16'd5, 1'b1);
		send_request(3, 1'b0, 0);
		send_request(7, 1'b0, 0);
		send_request(5, 1'b1, 0);
		// Oversized cylinder count, downward from the top
		set_config(sds_pkg::DIST_BITS'(131071), 16'd65535, 1'b0);
		send_request(65535, 1'b0, 0);
		send_request(0, 1'b0, 0);
		send_request(32768, 1'b1, 0);
		// Upward from the top with a turn of zero length
		set_config(sds_pkg::DIST_BITS'(65537), 16'd65535, 1'b1);
		send_request(65535, 1'b0, 0);
		send_request(1, 1'b1, 0);
		// Unused register index, then a one-cylinder disk
		wait_drained();
		write_reg(CFG_UNUSED, sds_pkg::DIST_BITS'($urandom));
		cfg_valid <= 1'b0;
		set_config(sds_pkg::DIST_BITS'(1), 16'd0, 1'b1);
		send_request(0, 1'b1, 0);

		// Random batches; settings change every few batches, one batch overflows the store
		while (items < RANDOM_ITEMS) begin
			if (batch_no % 3 == 0)
				set_config(pick_cyl_count(),
					($urandom_range(0, 2) == 0)
						? sds_pkg::CYL_BITS'($urandom_range(0, 1) * 65535)
						: sds_pkg::CYL_BITS'($urandom_range(0, 65535)),
					1'($urandom));
			r = $urandom_range(0, 19);
			if (batch_no == 2)
				size = sds_pkg::MAX_REQUESTS + 2;
			else if (r == 0)
				size = sds_pkg::MAX_REQUESTS;
			else
				size = $urandom_range(1, 8);
			burst = ($urandom_range(0, 9) < 3);
			for (int i = 0; i < size; i++) begin
				send_request(pick_cylinder(), i == size - 1, burst ? 0 : gap_len());
				items++;
			end
			batch_no++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.service_order.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/sds_pkg.sv
design/sds_front.sv
design/sds_queue.sv
design/sds_back.sv
design/scan_disk_scheduler.sv
dv/testbench.sv
